/* hw/rtl/clrf_pkg.sv */
// shared types and constants for the canvas line and rectangle painter
// no dependencies; imported by every module of the block

package clrf_pkg;

    // command codes on the input tuser field
    localparam logic [1:0] CMD_LINE = 2'd0;
    localparam logic [1:0] CMD_FILL = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // shades returned on a read
    localparam logic [2:0] SHADE_BLACK = 3'd0;
    localparam logic [2:0] SHADE_WHITE = 3'd4;

    // work kinds queued between front and back
    typedef enum logic {
        OP_PAINT,
        OP_READ
    } clrf_op_t;

    // back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAINT,
        ST_RDATA
    } clrf_state_t;

endpackage

/* hw/rtl/clrf_ram.sv */
// generic simple dual-port ram with per-bit write enable and registered read
// depends on clrf_pkg only for the common import convention

module clrf_ram
    import clrf_pkg::*;
#(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wmask,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // masked write, bit by bit
    always_ff @(posedge aclk) begin
        for (int i = 0; i < WIDTH; i++) begin
            if (we && wmask[i]) begin
                mem[waddr][i] <= wdata[i];
            end
        end
    end

    // registered read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/clrf_front.sv */
// front end: clamps corners into the canvas, normalizes and classifies commands
// depends on clrf_pkg; feeds clrf_queue

module clrf_front
    import clrf_pkg::*;
#(
    parameter int ROWS = 32,
    parameter int COLS = 64,
    localparam int ROW_W = $clog2(ROWS),
    localparam int COL_W = $clog2(COLS),
    localparam int EW = 1 + 2 * ROW_W + 2 * COL_W
) (
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [31:0]   s_tdata,
    input  logic [7:0]    s_tuser,
    output logic          push_valid,
    input  logic          push_ready,
    output logic [EW-1:0] push_data
);

    localparam logic [7:0] ROW_MAX = 8'(ROWS - 1);
    localparam logic [7:0] COL_MAX = 8'(COLS - 1);

    // negative goes to zero, past the edge goes to the edge
    function automatic logic [7:0] clamp8(input logic [7:0] v, input logic [7:0] maxv);
        logic [7:0] mag;
        mag = {1'b0, v[6:0]};
        if (v[7]) begin
            return 8'd0;
        end else if (mag > maxv) begin
            return maxv;
        end
        return mag;
    endfunction

    logic [1:0]       command;
    logic [ROW_W-1:0] r0, r1, rlo, rhi;
    logic [COL_W-1:0] c0, c1, clo, chi;
    logic [7:0]       r0_c, r1_c, c0_c, c1_c;
    clrf_op_t         op;
    logic             useful;

    assign command = s_tuser[1:0];
    assign r0_c = clamp8(s_tdata[7:0], ROW_MAX);
    assign c0_c = clamp8(s_tdata[15:8], COL_MAX);
    assign r1_c = clamp8(s_tdata[23:16], ROW_MAX);
    assign c1_c = clamp8(s_tdata[31:24], COL_MAX);
    assign r0 = r0_c[ROW_W-1:0];
    assign r1 = r1_c[ROW_W-1:0];
    assign c0 = c0_c[COL_W-1:0];
    assign c1 = c1_c[COL_W-1:0];

    // classify and normalize the box
    always_comb begin
        op     = OP_PAINT;
        useful = 1'b0;
        rlo    = (r0 < r1) ? r0 : r1;
        rhi    = (r0 < r1) ? r1 : r0;
        clo    = (c0 < c1) ? c0 : c1;
        chi    = (c0 < c1) ? c1 : c0;
        unique case (command)
            CMD_LINE: begin
                useful = (r0 == r1) || (c0 == c1);
            end
            CMD_FILL: begin
                useful = 1'b1;
            end
            CMD_READ: begin
                op     = OP_READ;
                useful = 1'b1;
                rlo    = r0;
                clo    = c0;
            end
            default: begin
                useful = 1'b0;
            end
        endcase
    end

    // meaningless commands are accepted and dropped here
    assign s_tready   = push_ready;
    assign push_valid = s_tvalid && useful;
    assign push_data  = {op, rlo, rhi, clo, chi};

endmodule

/* hw/rtl/clrf_queue.sv */
// short command queue between the front and back ends
// depends on clrf_pkg for the import convention

module clrf_queue
    import clrf_pkg::*;
#(
    parameter int WIDTH = 27,
    parameter int DEPTH = 2,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload slots, no reset
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hw/rtl/clrf_back.sv */
// back end: paints one masked row per cycle and serves pixel reads
// depends on clrf_pkg and clrf_ram; pops commands from clrf_queue

module clrf_back
    import clrf_pkg::*;
#(
    parameter int ROWS = 32,
    parameter int COLS = 64,
    localparam int ROW_W = $clog2(ROWS),
    localparam int COL_W = $clog2(COLS),
    localparam int EW = 1 + 2 * ROW_W + 2 * COL_W
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  logic [EW-1:0] pop_data,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata
);

    // each row word holds one black bit per pixel; a set bit is black
    localparam logic [COLS-1:0] ALL_ONES = {COLS{1'b1}};
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLS - 1);

    clrf_op_t         head_op;
    logic [ROW_W-1:0] head_rlo, head_rhi;
    logic [COL_W-1:0] head_clo, head_chi;
    logic [COLS-1:0]  head_mask;

    assign head_op  = clrf_op_t'(pop_data[EW-1]);
    assign head_rlo = pop_data[2*COL_W+2*ROW_W-1 -: ROW_W];
    assign head_rhi = pop_data[2*COL_W+ROW_W-1 -: ROW_W];
    assign head_clo = pop_data[2*COL_W-1 -: COL_W];
    assign head_chi = pop_data[COL_W-1:0];
    assign head_mask = (ALL_ONES << head_clo) & (ALL_ONES >> (COL_LAST - head_chi));

    clrf_state_t      state_reg, state_next;
    logic [ROW_W-1:0] row_reg, row_next, rhi_reg, rhi_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [COLS-1:0]  mask_reg, mask_next;
    logic             rvalid_reg, rvalid_next;
    logic [ROWS-1:0]  row_valid_reg, row_valid_next;
    logic             out_valid_reg, out_valid_next;
    logic [2:0]       out_shade_reg, out_shade_next;

    logic             ram_we, ram_re;
    logic [COLS-1:0]  ram_wmask, ram_rdata;
    logic             out_free;

    assign out_free = !out_valid_reg || m_tready;

    // sequencer: next state, ram controls and result register
    always_comb begin
        state_next     = state_reg;
        row_next       = row_reg;
        rhi_next       = rhi_reg;
        col_next       = col_reg;
        mask_next      = mask_reg;
        rvalid_next    = rvalid_reg;
        row_valid_next = row_valid_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_shade_next = out_shade_reg;
        pop_ready      = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        // a row never written holds garbage, so its first write covers the whole word
        ram_wmask      = row_valid_reg[row_reg] ? mask_reg : ALL_ONES;
        unique case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    if (head_op == OP_PAINT) begin
                        pop_ready  = 1'b1;
                        row_next   = head_rlo;
                        rhi_next   = head_rhi;
                        mask_next  = head_mask;
                        state_next = ST_PAINT;
                    end else if (out_free) begin
                        pop_ready   = 1'b1;
                        ram_re      = 1'b1;
                        col_next    = head_clo;
                        rvalid_next = row_valid_reg[head_rlo];
                        state_next  = ST_RDATA;
                    end
                end
            end
            ST_PAINT: begin
                ram_we = 1'b1;
                row_valid_next[row_reg] = 1'b1;
                if (row_reg == rhi_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            ST_RDATA: begin
                out_valid_next = 1'b1;
                out_shade_next = (rvalid_reg && ram_rdata[col_reg]) ? SHADE_BLACK : SHADE_WHITE;
                state_next     = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            row_valid_reg <= row_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        row_reg       <= row_next;
        rhi_reg       <= rhi_next;
        col_reg       <= col_next;
        mask_reg      <= mask_next;
        rvalid_reg    <= rvalid_next;
        out_shade_reg <= out_shade_next;
    end

    // pixel store, one row word per entry
    clrf_ram #(
        .WIDTH (COLS),
        .DEPTH (ROWS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (row_reg),
        .wmask (ram_wmask),
        .wdata (mask_reg),
        .re    (ram_re),
        .raddr (head_rlo),
        .rdata (ram_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_shade_reg};

endmodule

/* hw/rtl/canvas_line_rect_fill.sv */
// top level of the canvas line and rectangle painter
// depends on clrf_pkg, clrf_front, clrf_queue, clrf_back and clrf_ram
//
// Commands arrive on the s_ stream: tuser carries the command (line, fill,
// read), tdata the two corners as signed bytes. Corners are clamped into the
// ROWS by COLS canvas. Line and fill paint black and give no result; a read
// returns one beat on the m_ stream with the shade (0 black, 4 white).
// The front clamps and classifies in the accept cycle and pushes into a
// two-entry queue; the back sequencer works through the queue in order.
// A paint pops its command in the idle state and then, since the store writes
// one masked row word per cycle, writes rows rlo to rhi in the paint state.
// A read starts the store read when popped; ST_RDATA registers its shade for m_.
// Unused command codes and diagonal lines are accepted and dropped.
// Reset empties the queue and marks every row unwritten, so the canvas reads
// all white at once; no clearing pass is needed. When the receiver stalls,
// the result stays in the output register and the back holds the next read;
// paints ahead of that read keep going and input is taken until the queue fills.

module canvas_line_rect_fill
    import clrf_pkg::*;
#(
    parameter int ROWS = 32,
    parameter int COLS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // first_row, first_col, second_row, second_col
    input  logic [7:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // pixel_shade
);

    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLS);
    localparam int EW = 1 + 2 * ROW_W + 2 * COL_W;

    logic          push_valid, push_ready, pop_valid, pop_ready;
    logic [EW-1:0] push_data, pop_data;

    clrf_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    clrf_queue #(
        .WIDTH (EW),
        .DEPTH (2)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    clrf_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
